[rtl/core/msc_dgf_pkg.sv]
// ----------------------------------------------------------------------------
// msc_dgf_pkg
// Types, constants and the crc helper shared by the data group framer.
// ----------------------------------------------------------------------------
package msc_dgf_pkg;

    localparam int unsigned HDR_LEN = 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // ext=0, crc=1, seg=1, acc=1 in the upper nibble of the first byte
    localparam logic [3:0] HDR_FLAGS = 4'h7;
    // rfa=0, tid flag=1, length id=2
    localparam logic [7:0] HDR_ACC_BYTE = 8'h12;

    typedef struct packed {
        logic        start_group;
        logic [3:0]  group_type;
        logic [14:0] segment_index;
        logic        last_segment;
        logic [15:0] transport_id;
        logic [12:0] segment_length;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       group_end;
        logic       stray_error;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_BODY,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    // one emitted byte and the framer state that follows it
    typedef struct packed {
        t_out_item   res;
        t_phase      nxt_phase;
        logic [3:0]  nxt_cnt;
        logic [15:0] nxt_crc;
        logic [12:0] nxt_left;
        logic        nxt_open;
        logic        done;
    } t_step;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

[rtl/core/msc_dgf_step.sv]
// ----------------------------------------------------------------------------
// msc_dgf_step
// Works out the next framed byte of the item in flight and the state after it.
// ----------------------------------------------------------------------------
module msc_dgf_step (
    input  msc_dgf_pkg::t_in_item i_item,
    input  msc_dgf_pkg::t_phase   i_phase,
    input  logic [3:0]            i_cnt,
    input  logic [15:0]           i_crc,
    input  logic [12:0]           i_left,
    input  logic                  i_open,
    output msc_dgf_pkg::t_step    o_step
);

    logic [7:0]  hdr_byte;
    logic [15:0] crc_base;
    logic [12:0] left_dec;

    always_comb begin
        unique case (i_cnt)
            4'd0:    hdr_byte = {msc_dgf_pkg::HDR_FLAGS, i_item.group_type};
            4'd1:    hdr_byte = {i_item.segment_index[3:0], 4'h0};
            4'd2:    hdr_byte = {i_item.last_segment, i_item.segment_index[14:8]};
            4'd3:    hdr_byte = i_item.segment_index[7:0];
            4'd4:    hdr_byte = msc_dgf_pkg::HDR_ACC_BYTE;
            4'd5:    hdr_byte = i_item.transport_id[15:8];
            4'd6:    hdr_byte = i_item.transport_id[7:0];
            4'd7:    hdr_byte = {3'b000, i_item.segment_length[12:8]};
            4'd8:    hdr_byte = i_item.segment_length[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    // a new header restarts the crc regardless of any abandoned group
    assign crc_base = (i_cnt == 4'd0) ? msc_dgf_pkg::CRC_INIT : i_crc;
    assign left_dec = i_left - 13'd1;

    always_comb begin
        o_step.res       = '0;
        o_step.nxt_phase = i_phase;
        o_step.nxt_cnt   = i_cnt;
        o_step.nxt_crc   = i_crc;
        o_step.nxt_left  = i_left;
        o_step.nxt_open  = i_open;
        o_step.done      = 1'b0;
        unique case (i_phase)
            msc_dgf_pkg::PH_HDR: begin
                o_step.res.out_byte = hdr_byte;
                o_step.nxt_crc      = msc_dgf_pkg::crc_byte(crc_base, hdr_byte);
                if (i_cnt == 4'(msc_dgf_pkg::HDR_LEN - 1)) begin
                    o_step.nxt_open  = 1'b1;
                    o_step.nxt_left  = i_item.segment_length;
                    o_step.nxt_phase = (i_item.segment_length == '0) ?
                                       msc_dgf_pkg::PH_CRC_HI : msc_dgf_pkg::PH_BODY;
                end else begin
                    o_step.nxt_cnt = i_cnt + 4'd1;
                end
            end
            msc_dgf_pkg::PH_BODY: begin
                if (!i_open) begin
                    // stray byte: flagged and dropped
                    o_step.res.stray_error = 1'b1;
                    o_step.res.run_end     = 1'b1;
                    o_step.done            = 1'b1;
                end else begin
                    o_step.res.out_byte = i_item.payload_byte;
                    o_step.nxt_crc  = msc_dgf_pkg::crc_byte(i_crc, i_item.payload_byte);
                    o_step.nxt_left = left_dec;
                    if (left_dec == '0) begin
                        o_step.nxt_phase = msc_dgf_pkg::PH_CRC_HI;
                    end else begin
                        o_step.res.run_end = 1'b1;
                        o_step.done        = 1'b1;
                    end
                end
            end
            msc_dgf_pkg::PH_CRC_HI: begin
                o_step.res.out_byte = ~i_crc[15:8];
                o_step.nxt_phase    = msc_dgf_pkg::PH_CRC_LO;
            end
            msc_dgf_pkg::PH_CRC_LO: begin
                o_step.res.out_byte  = ~i_crc[7:0];
                o_step.res.group_end = 1'b1;
                o_step.res.run_end   = 1'b1;
                o_step.nxt_open      = 1'b0;
                o_step.nxt_left      = '0;
                o_step.nxt_crc       = msc_dgf_pkg::CRC_INIT;
                o_step.done          = 1'b1;
            end
            default: begin
                o_step.done = 1'b1;
            end
        endcase
    end

endmodule

[rtl/core/msc_data_group_framer_unit.sv]
// ----------------------------------------------------------------------------
// msc_data_group_framer_unit
// Frames payload bytes into msc data groups: header, payload, crc-16.
// ----------------------------------------------------------------------------
// The block emits one framed byte per clock, while the output is not stalled,
// through a single output register. An input item is held in an input register
// while its bytes go out: a byte that opens a group gives the HDR_LEN header
// bytes, its payload byte when the segment length is not zero, and the two crc
// bytes when the group closes; a stray byte gives one flagged result, and a
// plain payload byte gives its byte, then the two crc bytes if it ends a group.
// The next item is taken in the same cycle that the last byte of the current
// one enters the output register: unless the output stalls, payload bytes run at
// one byte per clock and the input stalls only around headers and crc bytes.
module msc_data_group_framer_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_vld,
    output logic                   o_in_stall,
    input  msc_dgf_pkg::t_in_item  i_in_data,
    output logic                   o_out_vld,
    input  logic                   i_out_stall,
    output msc_dgf_pkg::t_out_item o_out_data
);

    logic                   r_in_vld;
    msc_dgf_pkg::t_in_item  r_item;
    msc_dgf_pkg::t_phase    r_phase;
    logic [3:0]             r_cnt;
    logic [15:0]            r_crc;
    logic [12:0]            r_left;
    logic                   r_open;
    logic                   r_out_vld;
    msc_dgf_pkg::t_out_item r_out;

    msc_dgf_pkg::t_step     step;
    logic                   advance;
    logic                   in_take;

    msc_dgf_step u_step (
        .i_item  (r_item),
        .i_phase (r_phase),
        .i_cnt   (r_cnt),
        .i_crc   (r_crc),
        .i_left  (r_left),
        .i_open  (r_open),
        .o_step  (step)
    );

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !(advance && step.done);
    assign in_take    = i_in_vld && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= msc_dgf_pkg::PH_BODY;
            r_cnt     <= '0;
            r_crc     <= msc_dgf_pkg::CRC_INIT;
            r_left    <= '0;
            r_open    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
                r_phase  <= i_in_data.start_group ? msc_dgf_pkg::PH_HDR
                                                  : msc_dgf_pkg::PH_BODY;
                r_cnt    <= '0;
            end else if (advance) begin
                r_in_vld <= !step.done;
                r_phase  <= step.nxt_phase;
                r_cnt    <= step.nxt_cnt;
            end
            if (advance) begin
                r_crc     <= step.nxt_crc;
                r_left    <= step.nxt_left;
                r_open    <= step.nxt_open;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_data;
        end
        if (advance) begin
            r_out <= step.res;
        end
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out;

    // the closing crc byte always ends the run of its item
    a_gend_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_vld && o_out_data.group_end |-> o_out_data.run_end)
        else $error("group end without run end");

    // a stray result carries a zero byte, no group end, and ends its run
    a_stray_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_vld && o_out_data.stray_error |->
            o_out_data.run_end && !o_out_data.group_end && (o_out_data.out_byte == 8'h00))
        else $error("malformed stray result");

    // with no group open there is nothing left to count
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_left == '0))
        else $error("bytes left while no group open");

    // header counter stays inside the header
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(msc_dgf_pkg::HDR_LEN - 1))
        else $error("header counter out of range");

    // a crc byte is only sent while a group is open
    a_crc_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && (r_phase == msc_dgf_pkg::PH_CRC_HI || r_phase == msc_dgf_pkg::PH_CRC_LO)
            |-> r_open)
        else $error("crc phase with no group open");

endmodule
